// ----- rtl/depq_pkg.sv -----
`default_nettype none
package depq_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int CountW = 7;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_EXTRACT_MIN = 3'd1;
  localparam logic [2:0] OP_GET_MIN = 3'd2;
  localparam logic [2:0] OP_EXTRACT_MAX = 3'd3;
  localparam logic [2:0] OP_GET_MAX = 3'd4;
  localparam logic [2:0] OP_SIZE = 3'd5;
  localparam logic [2:0] OP_CLEAR = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // datapath commands
  localparam logic [2:0] DP_NONE = 3'd0;
  localparam logic [2:0] DP_LOAD = 3'd1;   // capture operand, set up search
  localparam logic [2:0] DP_SHIFT = 3'd2;  // one insert shift step
  localparam logic [2:0] DP_PLACE = 3'd3;  // write key at position
  localparam logic [2:0] DP_SHDOWN = 3'd4; // one extract-min shift step
  localparam logic [2:0] DP_RDMAX = 3'd5;  // read top entry
  localparam logic [2:0] DP_RDMIN = 3'd6;  // prefetch entry 1, position to bottom

  typedef struct packed {
    logic [2:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_done;   // insert search reached its slot
    logic sh_done;    // extract-min shift reached the end
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/depq_datapath.sv -----
`default_nettype none
module depq_datapath #(
  parameter int CAPACITY = depq_pkg::CAPACITY_DEF,
  parameter int IdxW = $clog2(CAPACITY + 1)
) (
  input  wire logic clk,
  input  wire depq_pkg::dp_cmd_t cmd,
  input  wire logic [31:0] operand,
  input  wire logic [IdxW-1:0] count,
  output depq_pkg::dp_stat_t stat,
  output logic [31:0] rd_value
);
  import depq_pkg::*;
  localparam int AW = $clog2(CAPACITY);

  logic [31:0] mem [CAPACITY];
  logic [31:0] key;
  logic [IdxW-1:0] pos;
  logic [31:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] pos_a;

  assign pos_a = pos[AW-1:0];

  // read address presented in the cycle before rd_q is used
  always_comb begin
    case (cmd.op)
      DP_LOAD: rd_addr = AW'(count - IdxW'(1));
      DP_SHIFT: rd_addr = AW'(pos - IdxW'(2));
      DP_SHDOWN: rd_addr = AW'(pos + IdxW'(2));
      DP_RDMAX: rd_addr = AW'(count - IdxW'(1));
      DP_RDMIN: rd_addr = AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    case (cmd.op)
      DP_SHIFT: mem[pos_a] <= rd_q;
      DP_PLACE: mem[pos_a] <= key;
      DP_SHDOWN: mem[pos_a] <= rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        key <= operand ^ 32'h8000_0000;
        pos <= count;
      end
      DP_SHIFT: pos <= pos - IdxW'(1);
      DP_SHDOWN: pos <= pos + IdxW'(1);
      DP_RDMAX: pos <= '0;
      DP_RDMIN: pos <= '0;
      default: ;
    endcase
  end

  // rd_q holds mem[pos-1] during insert search, mem[pos+1] during shift down
  assign stat.ins_done = (pos == '0) || !(rd_q > key);
  assign stat.sh_done = (pos + IdxW'(1) >= count);
  assign rd_value = rd_q;
endmodule
`default_nettype wire

// ----- rtl/depq_ctrl.sv -----
`default_nettype none
module depq_ctrl #(
  parameter int CAPACITY = depq_pkg::CAPACITY_DEF,
  parameter int IdxW = $clog2(CAPACITY + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] opcode,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic [31:0] result_value,
  output logic [IdxW-1:0] count,
  output depq_pkg::dp_cmd_t cmd,
  input  wire depq_pkg::dp_stat_t stat,
  input  wire logic [31:0] rd_value
);
  import depq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS = 3'd1;
  localparam logic [2:0] S_SHD = 3'd3;
  localparam logic [2:0] S_MAXRD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_MIN0 = 3'd6;

  logic [2:0] state;
  logic [2:0] op;
  logic accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd.op = DP_NONE;
    case (state)
      S_IDLE: if (accept && opcode == OP_INSERT) cmd.op = DP_LOAD;
              else if (accept && (opcode == OP_GET_MAX || opcode == OP_EXTRACT_MAX))
                cmd.op = DP_RDMAX;
      S_INS: cmd.op = stat.ins_done ? DP_PLACE : DP_SHIFT;
      S_MIN0: cmd.op = DP_RDMIN;
      S_SHD: if (!stat.sh_done) cmd.op = DP_SHDOWN;
      default: ;
    endcase
  end

  // min read: address 0 is presented at accept (DP_NONE reads mem[0])
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          op <= opcode;
          status <= ST_OK;
          result_value <= '0;
          case (opcode)
            OP_INSERT:
              if (count >= IdxW'(CAPACITY)) begin
                status <= ST_FULL;
                state <= S_OUT;
              end else state <= S_INS;
            OP_EXTRACT_MIN, OP_GET_MIN, OP_EXTRACT_MAX, OP_GET_MAX:
              if (count == '0) begin
                status <= ST_EMPTY;
                state <= S_OUT;
              end else if (opcode == OP_EXTRACT_MIN || opcode == OP_GET_MIN)
                state <= S_MIN0;
              else state <= S_MAXRD;
            OP_CLEAR: begin
              count <= '0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_INS: if (stat.ins_done) begin
          count <= count + IdxW'(1);
          state <= S_OUT;
        end
        S_MIN0: begin
          result_value <= rd_value ^ 32'h8000_0000;
          state <= (op == OP_EXTRACT_MIN) ? S_SHD : S_OUT;
        end
        S_SHD: if (stat.sh_done) begin
          count <= count - IdxW'(1);
          state <= S_OUT;
        end
        S_MAXRD: begin
          result_value <= rd_value ^ 32'h8000_0000;
          if (op == OP_EXTRACT_MAX) count <= count - IdxW'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/double_ended_priority_queue_unit.sv -----
`default_nettype none
// Double-ended priority queue over signed 32-bit words, up to CAPACITY entries kept
// ascending in one single-port-write RAM. Size, clear, the unused opcode and every empty
// or full result go straight to the result state; min and max reads and max removal
// take one RAM read; min removal then moves every later entry down one slot and insert
// moves every larger entry up one slot before placing the key, one RAM move per cycle.
// One command is in flight at a time; a waiting result does not block acceptance
// beyond being taken. Reset needs no clearing pass.
module double_ended_priority_queue_unit #(
  parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [39:0] s_tdata,   // opcode[2:0], operand_value[34:3], zero pad
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [47:0] m_tdata         // status[1:0], result_value[33:2], entry_count[40:34]
);
  import depq_pkg::*;
  localparam int IdxW = $clog2(CAPACITY + 1);

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [31:0] rd_value;
  logic [IdxW-1:0] count;
  logic [1:0] status;
  logic [31:0] result_value;

  depq_datapath #(.CAPACITY(CAPACITY), .IdxW(IdxW)) u_dp (
    .clk(clk), .cmd(cmd), .operand(s_tdata[34:3]), .count(count),
    .stat(stat), .rd_value(rd_value)
  );

  depq_ctrl #(.CAPACITY(CAPACITY), .IdxW(IdxW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .opcode(s_tdata[2:0]), .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .result_value(result_value), .count(count),
    .cmd(cmd), .stat(stat), .rd_value(rd_value)
  );

  assign m_tdata = {7'd0, CountW'(count), result_value, status};

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    count <= IdxW'(CAPACITY)) else $error("count over capacity");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second word accepted");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_EMPTY) |-> m_tdata[33:2] == 32'd0)
    else $error("empty result nonzero");
endmodule
`default_nettype wire
